>>> design/windowed_percentile_thread_governor_unit_assert.svh
`ifndef WINDOWED_PERCENTILE_THREAD_GOVERNOR_UNIT_ASSERT_SVH
`define WINDOWED_PERCENTILE_THREAD_GOVERNOR_UNIT_ASSERT_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define WPTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define WPTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/wptg_pkg.sv
package wptg_pkg;

    localparam int MaxWindow      = 64;
    localparam int MinWindow      = 4;
    localparam int DefaultWindow  = 16;
    localparam int DefaultThreads = 4;
    localparam int DownStep       = 2;
    localparam int UpStep         = 1;

    localparam int SampleWidth  = 16;
    localparam int ThreadWidth  = 7;
    localparam int CountWidth   = $clog2(MaxWindow + 1);
    localparam int TimeWidth    = 40;
    localparam int DataWidth    = 32;
    localparam int DividendWidth = DataWidth + 12;
    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] CfgMinThreads      = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgMaxThreads      = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgLagThreshold    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgStableThreshold = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgStableWindows   = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CfgMinInterval     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CfgTargetEvals     = 3'd6;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic                   valid;
        logic [SampleWidth-1:0] value;
    } cell_data_t;

endpackage

>>> design/wptg_cell.sv
module wptg_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wptg_pkg::cell_op_t              op,
    input  logic [wptg_pkg::SampleWidth-1:0] sample,
    input  wptg_pkg::cell_data_t            left,
    input  logic                            left_le,
    input  wptg_pkg::cell_data_t            right,
    output wptg_pkg::cell_data_t            data,
    output logic                            le
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [wptg_pkg::SampleWidth-1:0] value_reg;
    logic [wptg_pkg::SampleWidth-1:0] value_next;

    assign le         = valid_reg && (value_reg <= sample);
    assign data.valid = valid_reg;
    assign data.value = value_reg;

    // The row stays sorted with occupied cells first; an insert opens a gap
    // at the first cell that is empty or holds a value above the new sample.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        case (op)
            wptg_pkg::CELL_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        value_next = sample;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        value_next = left.value;
                    end
                end
            end
            wptg_pkg::CELL_SHIFT:
            begin
                valid_next = right.valid;
                value_next = right.value;
            end
            wptg_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> design/wptg_div.sv
module wptg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [wptg_pkg::DividendWidth-1:0] dividend,
    input  logic [wptg_pkg::DataWidth-1:0]     divisor,
    output logic                              done,
    output logic [wptg_pkg::DividendWidth-1:0] quotient
);

    localparam int StepWidth = $clog2(wptg_pkg::DividendWidth);
    localparam logic [StepWidth-1:0] LastStep = StepWidth'(wptg_pkg::DividendWidth - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [StepWidth-1:0]               step_reg;
    logic [wptg_pkg::DataWidth-1:0]     rem_reg;
    logic [wptg_pkg::DataWidth-1:0]     rem_next;
    logic [wptg_pkg::DividendWidth-1:0] quo_reg;
    logic [wptg_pkg::DividendWidth-1:0] quo_next;
    logic [wptg_pkg::DataWidth-1:0]     dsr_reg;
    logic [wptg_pkg::DataWidth:0]       shifted;
    logic [wptg_pkg::DataWidth:0]       diff;
    logic                               fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[wptg_pkg::DividendWidth-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[wptg_pkg::DataWidth-1:0] : shifted[wptg_pkg::DataWidth-1:0];
        quo_next = {quo_reg[wptg_pkg::DividendWidth-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

>>> design/windowed_percentile_thread_governor_unit.sv
// Thread governor that keeps each job's processing-to-audio ratio in a sorted
// row of 64 cells and, once a window is full, steps the thread count from the
// 75th percentile. One request at a time is worked on. A request with zero
// audio length goes straight from idle to the result state. Any other request
// is paced by the shared 44-step bit-serial divider, used first to recalibrate
// the window when a new day with a nonzero count arrives; when the request
// completes a window of n samples, the cell row shifts out floor(3n/4) samples
// to reach the percentile. The next request is taken while the previous result
// waits on the result port.
`include "windowed_percentile_thread_governor_unit_assert.svh"

module windowed_percentile_thread_governor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        job_valid,
    output logic        job_ready,
    input  logic [31:0] processing_ms,
    input  logic [31:0] audio_ms,
    input  logic [39:0] time_ms,
    input  logic        new_day,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [6:0]  active_threads,
    output logic [6:0]  window_len,
    output logic [15:0] percentile_ratio,
    output logic        evaluated,
    output logic        adjusted,
    output logic        ignored
);

    localparam int Cells = wptg_pkg::MaxWindow;
    localparam int CW    = wptg_pkg::CountWidth;
    localparam int TW    = wptg_pkg::ThreadWidth;
    localparam int SW    = wptg_pkg::SampleWidth;
    localparam int DW    = wptg_pkg::DividendWidth;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECAL_START,
        S_RECAL_WAIT,
        S_RATIO_START,
        S_RATIO_WAIT,
        S_INSERT,
        S_CHECK,
        S_SHIFT,
        S_DECIDE,
        S_RESULT
    } state_t;

    state_t state_reg;

    logic [TW-1:0] min_threads_reg;
    logic [TW-1:0] max_threads_reg;
    logic [SW-1:0] lag_thr_reg;
    logic [SW-1:0] stable_thr_reg;
    logic [7:0]    stable_needed_reg;
    logic [31:0]   interval_reg;
    logic [10:0]   target_evals_reg;

    logic [CW-1:0] count_reg;
    logic [TW-1:0] window_reg;
    logic [TW-1:0] threads_reg;
    logic [7:0]    stable_run_reg;
    logic [39:0]   last_change_reg;
    logic [31:0]   today_reg;
    logic [31:0]   yesterday_reg;

    logic [31:0]   proc_reg;
    logic [31:0]   audio_reg;
    logic [39:0]   time_reg;
    logic [SW-1:0] ratio_reg;
    logic [CW-1:0] rank_reg;
    logic [CW-1:0] shift_cnt_reg;
    logic [SW-1:0] pct_reg;
    logic          eval_reg;
    logic          adj_reg;
    logic          ign_reg;

    logic          out_valid_reg;
    logic [TW-1:0] out_threads_reg;
    logic [TW-1:0] out_window_reg;
    logic [SW-1:0] out_pct_reg;
    logic          out_eval_reg;
    logic          out_adj_reg;
    logic          out_ign_reg;

    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [31:0]          div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quotient;
    logic [10:0]          target_eff;
    logic [TW-1:0]        new_window;
    logic [CW+1:0]        triple;

    wptg_pkg::cell_op_t   cell_op;
    wptg_pkg::cell_data_t cell_data [Cells];
    logic                 cell_le [Cells];
    logic [Cells-1:0]     valid_vec;

    logic          job_accept;
    logic          allowed;
    logic [40:0]   elapsed;
    logic [SW-1:0] pct_now;
    logic [8:0]    run_inc;
    logic [7:0]    run_sat;
    logic [TW:0]   down_floor;
    logic [TW-1:0] threads_down;
    logic [TW:0]   up_sum;
    logic [TW-1:0] threads_up;

    assign job_ready  = (state_reg == S_IDLE);
    assign job_accept = job_valid && job_ready;

    assign result_valid     = out_valid_reg;
    assign active_threads   = out_threads_reg;
    assign window_len       = out_window_reg;
    assign percentile_ratio = out_pct_reg;
    assign evaluated        = out_eval_reg;
    assign adjusted         = out_adj_reg;
    assign ignored          = out_ign_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_threads_reg   <= TW'(2);
            max_threads_reg   <= TW'(16);
            lag_thr_reg       <= SW'(4096);
            stable_thr_reg    <= SW'(2048);
            stable_needed_reg <= 8'd3;
            interval_reg      <= 32'd30000;
            target_evals_reg  <= 11'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wptg_pkg::CfgMinThreads:      min_threads_reg   <= cfg_data[TW-1:0];
                wptg_pkg::CfgMaxThreads:      max_threads_reg   <= cfg_data[TW-1:0];
                wptg_pkg::CfgLagThreshold:    lag_thr_reg       <= cfg_data[SW-1:0];
                wptg_pkg::CfgStableThreshold: stable_thr_reg    <= cfg_data[SW-1:0];
                wptg_pkg::CfgStableWindows:   stable_needed_reg <= cfg_data[7:0];
                wptg_pkg::CfgMinInterval:     interval_reg      <= cfg_data;
                wptg_pkg::CfgTargetEvals:     target_evals_reg  <= cfg_data[10:0];
                default:                      interval_reg      <= interval_reg;
            endcase
        end
    end

    // Shared divider: window recalibration, then the job ratio.
    assign target_eff   = (target_evals_reg == '0) ? 11'd1 : target_evals_reg;
    assign div_start    = (state_reg == S_RECAL_START) || (state_reg == S_RATIO_START);
    assign div_dividend = (state_reg == S_RECAL_START) ? {12'd0, yesterday_reg}
                                                       : {proc_reg, 12'd0};
    assign div_divisor  = (state_reg == S_RECAL_START) ? {21'd0, target_eff} : audio_reg;

    wptg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        if (div_quotient > DW'(wptg_pkg::MaxWindow))
        begin
            new_window = TW'(wptg_pkg::MaxWindow);
        end
        else if (div_quotient < DW'(wptg_pkg::MinWindow))
        begin
            new_window = TW'(wptg_pkg::MinWindow);
        end
        else
        begin
            new_window = div_quotient[TW-1:0];
        end
    end

    // Sorted row of sample cells.
    always_comb
    begin
        case (state_reg)
            S_RECAL_WAIT: cell_op = (div_done && (new_window != window_reg))
                                    ? wptg_pkg::CELL_CLEAR : wptg_pkg::CELL_HOLD;
            S_INSERT:     cell_op = (count_reg < CW'(Cells))
                                    ? wptg_pkg::CELL_INSERT : wptg_pkg::CELL_HOLD;
            S_SHIFT:      cell_op = (shift_cnt_reg != rank_reg)
                                    ? wptg_pkg::CELL_SHIFT : wptg_pkg::CELL_HOLD;
            S_DECIDE:     cell_op = wptg_pkg::CELL_CLEAR;
            default:      cell_op = wptg_pkg::CELL_HOLD;
        endcase
    end

    for (genvar i = 0; i < Cells; i++)
    begin : g_cell
        wptg_pkg::cell_data_t left_d;
        wptg_pkg::cell_data_t right_d;
        logic                 left_le_d;

        if (i == 0)
        begin : g_first
            assign left_d    = '0;
            assign left_le_d = 1'b1;
        end
        else
        begin : g_mid
            assign left_d    = cell_data[i-1];
            assign left_le_d = cell_le[i-1];
        end

        if (i == Cells - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        wptg_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .op      (cell_op),
            .sample  (ratio_reg),
            .left    (left_d),
            .left_le (left_le_d),
            .right   (right_d),
            .data    (cell_data[i]),
            .le      (cell_le[i])
        );

        assign valid_vec[i] = cell_data[i].valid;
    end

    // Evaluation arithmetic.
    assign triple  = (CW + 2)'(count_reg) * (CW + 2)'(3);
    assign pct_now = cell_data[0].value;
    assign elapsed = {1'b0, time_reg} - {1'b0, last_change_reg};
    assign allowed = (time_reg >= last_change_reg) && (elapsed[39:0] >= {8'd0, interval_reg});
    assign run_inc = {1'b0, stable_run_reg} + 9'd1;
    assign run_sat = run_inc[8] ? 8'hFF : run_inc[7:0];

    assign down_floor   = {1'b0, min_threads_reg} + (TW + 1)'(wptg_pkg::DownStep);
    assign threads_down = ({1'b0, threads_reg} < down_floor)
                          ? min_threads_reg : threads_reg - TW'(wptg_pkg::DownStep);
    assign up_sum       = {1'b0, threads_reg} + (TW + 1)'(wptg_pkg::UpStep);
    assign threads_up   = (up_sum > {1'b0, max_threads_reg}) ? max_threads_reg : up_sum[TW-1:0];

    // Control sequencer and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            window_reg      <= TW'(wptg_pkg::DefaultWindow);
            threads_reg     <= TW'(wptg_pkg::DefaultThreads);
            stable_run_reg  <= '0;
            last_change_reg <= '0;
            today_reg       <= '0;
            yesterday_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_RESULT) && (!out_valid_reg || result_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_accept)
                    begin
                        if (audio_ms == '0)
                        begin
                            state_reg <= S_RESULT;
                        end
                        else if (new_day)
                        begin
                            yesterday_reg <= today_reg;
                            today_reg     <= 32'd1;
                            state_reg     <= (today_reg != '0) ? S_RECAL_START : S_RATIO_START;
                        end
                        else
                        begin
                            if (today_reg != 32'hFFFF_FFFF)
                            begin
                                today_reg <= today_reg + 32'd1;
                            end
                            state_reg <= S_RATIO_START;
                        end
                    end
                end
                S_RECAL_START:
                begin
                    state_reg <= S_RECAL_WAIT;
                end
                S_RECAL_WAIT:
                begin
                    if (div_done)
                    begin
                        if (new_window != window_reg)
                        begin
                            window_reg <= new_window;
                            count_reg  <= '0;
                        end
                        state_reg <= S_RATIO_START;
                    end
                end
                S_RATIO_START:
                begin
                    state_reg <= S_RATIO_WAIT;
                end
                S_RATIO_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_INSERT;
                    end
                end
                S_INSERT:
                begin
                    if (count_reg < CW'(Cells))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if ((count_reg >= CW'(window_reg)) || (count_reg >= CW'(Cells)))
                    begin
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_SHIFT:
                begin
                    if (shift_cnt_reg == rank_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    count_reg <= '0;
                    if (allowed)
                    begin
                        if (pct_now > lag_thr_reg)
                        begin
                            threads_reg     <= threads_down;
                            stable_run_reg  <= '0;
                            last_change_reg <= time_reg;
                        end
                        else if (pct_now < stable_thr_reg)
                        begin
                            if (run_sat >= stable_needed_reg)
                            begin
                                threads_reg     <= threads_up;
                                stable_run_reg  <= '0;
                                last_change_reg <= time_reg;
                            end
                            else
                            begin
                                stable_run_reg <= run_sat;
                            end
                        end
                        else
                        begin
                            stable_run_reg <= '0;
                        end
                    end
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || result_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Per-request working values and the result register.
    always_ff @(posedge clk)
    begin
        if (job_accept)
        begin
            proc_reg  <= processing_ms;
            audio_reg <= audio_ms;
            time_reg  <= time_ms;
            pct_reg   <= '0;
            eval_reg  <= 1'b0;
            adj_reg   <= 1'b0;
            ign_reg   <= (audio_ms == '0);
        end
        if ((state_reg == S_RATIO_WAIT) && div_done)
        begin
            ratio_reg <= (div_quotient[DW-1:SW] != '0) ? {SW{1'b1}} : div_quotient[SW-1:0];
        end
        if (state_reg == S_CHECK)
        begin
            rank_reg      <= triple[CW+1:2];
            shift_cnt_reg <= '0;
        end
        if ((state_reg == S_SHIFT) && (shift_cnt_reg != rank_reg))
        begin
            shift_cnt_reg <= shift_cnt_reg + 1'b1;
        end
        if (state_reg == S_DECIDE)
        begin
            pct_reg  <= pct_now;
            eval_reg <= 1'b1;
            adj_reg  <= allowed && ((pct_now > lag_thr_reg) ||
                        ((pct_now < stable_thr_reg) && (run_sat >= stable_needed_reg)));
        end
        if ((state_reg == S_RESULT) && (!out_valid_reg || result_ready))
        begin
            out_threads_reg <= threads_reg;
            out_window_reg  <= window_reg;
            out_pct_reg     <= pct_reg;
            out_eval_reg    <= eval_reg;
            out_adj_reg     <= adj_reg;
            out_ign_reg     <= ign_reg;
        end
    end

    `WPTG_ASSERT_IMP(a_cells_packed, clk, rst_n, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0, "occupied cells are not packed at the head of the row")
    `WPTG_ASSERT_IMP(a_count_match, clk, rst_n, state_reg == S_IDLE, $countones(valid_vec) == 32'(count_reg), "sample count disagrees with occupied cells")
    `WPTG_ASSERT_IMP(a_window_open, clk, rst_n, state_reg == S_IDLE, count_reg < CW'(window_reg), "idle with a full window")
    `WPTG_ASSERT_NXT(a_threads_hold, clk, rst_n, state_reg != S_DECIDE, $stable(threads_reg), "thread count changed outside a decision")

endmodule

>>> sim/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] proc_ms;
        logic [31:0] aud_ms;
        logic [39:0] stamp;
        logic        day;
    } job_t;

    typedef struct packed {
        logic [6:0]  threads;
        logic [6:0]  window;
        logic [15:0] pct;
        logic        eval;
        logic        adj;
        logic        ign;
    } verdict_t;

    typedef struct {
        job_t     job;
        logic     has_fixed;
        verdict_t fixed;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = wptg_pkg::CfgMinThreads;
    logic [31:0] cfg_data = '0;
    logic        job_valid = 1'b0;
    logic        job_ready;
    logic [31:0] processing_ms = '0;
    logic [31:0] audio_ms = '0;
    logic [39:0] time_ms = '0;
    logic        new_day = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [6:0]  active_threads;
    logic [6:0]  window_len;
    logic [15:0] percentile_ratio;
    logic        evaluated;
    logic        adjusted;
    logic        ignored;

    windowed_percentile_thread_governor_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Governor state as predicted.
    logic [6:0]  gv_min_thr, gv_max_thr;
    logic [15:0] gv_lag, gv_stable;
    logic [7:0]  gv_need;
    logic [31:0] gv_interval;
    logic [10:0] gv_target;
    logic [15:0] gv_samples [wptg_pkg::MaxWindow];
    int unsigned gv_count, gv_window, gv_threads, gv_run;
    logic [39:0] gv_last_change;
    logic [31:0] gv_today, gv_yesterday;

    verdict_t    pending_verdicts [$];
    row_t        rows [$];
    int          errors = 0;
    int          results_seen = 0;
    int          evals_seen = 0;
    int          adjusts_seen = 0;
    int          idle_cycles = 0;
    logic        rx_hold = 1'b0;
    logic [39:0] clock_ms = '0;

    function automatic logic [15:0] window_percentile(int unsigned n);
        logic [15:0] sorted [$];
        for (int i = 0; i < n; i++)
        begin
            sorted.insert(sorted.size(), gv_samples[i]);
        end
        sorted.sort();
        return sorted[(n * 3) / 4];
    endfunction

    function automatic verdict_t govern(job_t j);
        verdict_t    v;
        logic [43:0] ratio;
        int unsigned w;
        int          t;
        v = '0;
        if (j.aud_ms == 0)
        begin
            v.ign = 1'b1;
        end
        else
        begin
            ratio = {j.proc_ms, 12'd0} / j.aud_ms;
            if (ratio > 44'hFFFF)
            begin
                ratio = 44'hFFFF;
            end
            if (j.day)
            begin
                gv_yesterday = gv_today;
                gv_today = 0;
                if (gv_yesterday != 0)
                begin
                    w = gv_yesterday / ((gv_target == 0) ? 1 : gv_target);
                    if (w < wptg_pkg::MinWindow) w = wptg_pkg::MinWindow;
                    if (w > wptg_pkg::MaxWindow) w = wptg_pkg::MaxWindow;
                    if (w != gv_window)
                    begin
                        gv_window = w;
                        gv_count = 0;
                    end
                end
            end
            if (gv_today != 32'hFFFF_FFFF) gv_today++;
            if (gv_count < wptg_pkg::MaxWindow)
            begin
                gv_samples[gv_count] = ratio[15:0];
                gv_count++;
            end
            if (gv_count >= gv_window || gv_count >= wptg_pkg::MaxWindow)
            begin
                v.eval = 1'b1;
                v.pct = window_percentile(gv_count);
                if (j.stamp >= gv_last_change && (j.stamp - gv_last_change) >= gv_interval)
                begin
                    if (v.pct > gv_lag)
                    begin
                        t = int'(gv_threads) - wptg_pkg::DownStep;
                        if (t < int'(gv_min_thr)) t = gv_min_thr;
                        gv_threads = t;
                        gv_run = 0;
                        gv_last_change = j.stamp;
                        v.adj = 1'b1;
                    end
                    else if (v.pct < gv_stable)
                    begin
                        if (gv_run < 255) gv_run++;
                        if (gv_run >= gv_need)
                        begin
                            t = gv_threads + wptg_pkg::UpStep;
                            if (t > int'(gv_max_thr)) t = gv_max_thr;
                            gv_threads = t;
                            gv_run = 0;
                            gv_last_change = j.stamp;
                            v.adj = 1'b1;
                        end
                    end
                    else
                    begin
                        gv_run = 0;
                    end
                end
                gv_count = 0;
            end
        end
        v.threads = gv_threads[6:0];
        v.window = gv_window[6:0];
        return v;
    endfunction

    function automatic void add_row(job_t j, logic has_fixed, verdict_t fixed);
        row_t r;
        r.job = j;
        r.has_fixed = has_fixed;
        r.fixed = fixed;
        rows.insert(rows.size(), r);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wptg_pkg::CfgMinThreads:      gv_min_thr = val[6:0];
            wptg_pkg::CfgMaxThreads:      gv_max_thr = val[6:0];
            wptg_pkg::CfgLagThreshold:    gv_lag = val[15:0];
            wptg_pkg::CfgStableThreshold: gv_stable = val[15:0];
            wptg_pkg::CfgStableWindows:   gv_need = val[7:0];
            wptg_pkg::CfgMinInterval:     gv_interval = val;
            wptg_pkg::CfgTargetEvals:     gv_target = val[10:0];
            default: ;
        endcase
    endtask

    // Valid stays high after an acceptance until the next item or a pause.
    task automatic send_job(job_t j, logic has_fixed, verdict_t fixed, bit no_gap);
        verdict_t v;
        int       gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            job_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_valid <= 1'b1;
        processing_ms <= j.proc_ms;
        audio_ms <= j.aud_ms;
        time_ms <= j.stamp;
        new_day <= j.day;
        do @(posedge clk); while (!job_ready);
        v = govern(j);
        if (has_fixed && v != fixed)
        begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with governor: table %h governor %h", fixed, v);
        end
        pending_verdicts.insert(pending_verdicts.size(), v);
    endtask

    task automatic wait_drained();
        job_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic job_t rand_job();
        job_t j;
        j.aud_ms = $urandom_range(500, 60000);
        case ($urandom_range(0, 5))
            0: j.proc_ms = $urandom_range(0, j.aud_ms / 4);
            1: j.proc_ms = $urandom_range(j.aud_ms / 4, j.aud_ms);
            2: j.proc_ms = $urandom_range(j.aud_ms, j.aud_ms * 3);
            3: j.proc_ms = $urandom();
            default: j.proc_ms = $urandom_range(0, j.aud_ms * 2);
        endcase
        if ($urandom_range(0, 40) == 0) j.aud_ms = 0;
        if ($urandom_range(0, 30) == 0) j.aud_ms = $urandom();
        clock_ms = clock_ms + $urandom_range(0, 20000);
        if ($urandom_range(0, 60) == 0) clock_ms = {$urandom(), 8'h00} | {$urandom()};
        j.stamp = clock_ms;
        if ($urandom_range(0, 50) == 0) j.stamp = 40'({$urandom(), $urandom()});
        j.day = ($urandom_range(0, 70) == 0);
        return j;
    endfunction

    // Result checking.
    always @(posedge clk)
    begin
        verdict_t got, want;
        if (result_valid && result_ready)
        begin
            got = '{active_threads, window_len, percentile_ratio, evaluated, adjusted, ignored};
            results_seen <= results_seen + 1;
            if (evaluated) evals_seen <= evals_seen + 1;
            if (adjusted) adjusts_seen <= adjusts_seen + 1;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected thr=%0d win=%0d pct=%h e=%b a=%b i=%b",
                                 want.threads, want.window, want.pct, want.eval, want.adj,
                                 want.ign);
                        $display("          actual   thr=%0d win=%0d pct=%h e=%b a=%b i=%b",
                                 got.threads, got.window, got.pct, got.eval, got.adj,
                                 got.ign);
                    end
                end
            end
        end
    end

    // Receiver stalls.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                result_ready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (wait_cycles > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                result_ready <= 1'b1;
                do @(posedge clk); while (!result_valid && !rx_hold);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if ((job_valid && job_ready) || (result_valid && result_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        verdict_t nv;
        job_t     j;
        int       burst;
        gv_min_thr = 2; gv_max_thr = 16; gv_lag = 4096; gv_stable = 2048;
        gv_need = 3; gv_interval = 30000; gv_target = 10;
        gv_count = 0; gv_window = wptg_pkg::DefaultWindow;
        gv_threads = wptg_pkg::DefaultThreads;
        gv_run = 0; gv_last_change = '0; gv_today = '0; gv_yesterday = '0;
        nv = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table: zero audio, extreme ratios, new days, full windows.
        add_row('{32'd100, 32'd0, 40'd0, 1'b1}, 1'b1,
                '{7'd4, 7'd16, 16'd0, 1'b0, 1'b0, 1'b1});
        add_row('{32'hFFFF_FFFF, 32'd1, 40'd5, 1'b0}, 1'b1,
                '{7'd4, 7'd16, 16'd0, 1'b0, 1'b0, 1'b0});
        add_row('{32'd0, 32'hFFFF_FFFF, 40'd6, 1'b0}, 1'b1,
                '{7'd4, 7'd16, 16'd0, 1'b0, 1'b0, 1'b0});
        for (int k = 0; k < 13; k++)
            add_row('{32'd8000, 32'd1000, 40'd100, 1'b0}, 1'b0, nv);
        add_row('{32'd8000, 32'd1000, 40'd40000, 1'b0}, 1'b1,
                '{7'd2, 7'd16, 16'h8000, 1'b1, 1'b1, 1'b0});
        add_row('{32'd1, 32'd1, 40'hFF_FFFF_FFFF, 1'b1}, 1'b0, nv);
        add_row('{32'd1, 32'd2, 40'hFF_FFFF_FFFF, 1'b0}, 1'b0, nv);
        add_row('{32'd0, 32'd3, 40'd0, 1'b1}, 1'b0, nv);
        foreach (rows[r]) send_job(rows[r].job, rows[r].has_fixed, rows[r].fixed, 1'b0);
        wait_drained();

        // Random phases, one register setting each, extremes included.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin write_reg(wptg_pkg::CfgMinThreads, 1);
                         write_reg(wptg_pkg::CfgMaxThreads, 64);
                         write_reg(wptg_pkg::CfgLagThreshold, 4096);
                         write_reg(wptg_pkg::CfgStableThreshold, 2048);
                         write_reg(wptg_pkg::CfgStableWindows, 1);
                         write_reg(wptg_pkg::CfgMinInterval, 0);
                         write_reg(wptg_pkg::CfgTargetEvals, 1); end
                1: begin write_reg(wptg_pkg::CfgMinThreads, 64);
                         write_reg(wptg_pkg::CfgMaxThreads, 1);
                         write_reg(wptg_pkg::CfgLagThreshold, 65535);
                         write_reg(wptg_pkg::CfgStableThreshold, 65535);
                         write_reg(wptg_pkg::CfgStableWindows, 255);
                         write_reg(wptg_pkg::CfgTargetEvals, 1024); end
                2: begin write_reg(wptg_pkg::CfgMinThreads, 3);
                         write_reg(wptg_pkg::CfgMaxThreads, 12);
                         write_reg(wptg_pkg::CfgLagThreshold, 0);
                         write_reg(wptg_pkg::CfgStableThreshold, 0);
                         write_reg(wptg_pkg::CfgMinInterval, 32'hFFFF_FFFF);
                         write_reg(wptg_pkg::CfgTargetEvals, 0); end
                default: begin
                    write_reg(wptg_pkg::CfgMinThreads, $urandom_range(1, 8));
                    write_reg(wptg_pkg::CfgMaxThreads, $urandom_range(8, 64));
                    write_reg(wptg_pkg::CfgLagThreshold, $urandom_range(2048, 8192));
                    write_reg(wptg_pkg::CfgStableThreshold, $urandom_range(512, 4096));
                    write_reg(wptg_pkg::CfgStableWindows, $urandom_range(1, 4));
                    write_reg(wptg_pkg::CfgMinInterval, $urandom_range(0, 40000));
                    write_reg(wptg_pkg::CfgTargetEvals, $urandom_range(1, 40));
                end
            endcase
            for (int n = 0; n < 190; n++)
            begin
                j = rand_job();
                if (phase == 4 && n == 60)
                begin
                    rx_hold = 1'b1;
                    fork
                        begin
                            repeat (600) @(posedge clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                    for (burst = 0; burst < 6; burst++)
                        send_job(rand_job(), 1'b0, nv, 1'b1);
                end
                if (phase == 5 && n == 90)
                begin
                    job_valid <= 1'b0;
                    while (pending_verdicts.size() != 0) @(posedge clk);
                end
                send_job(j, 1'b0, nv, ($urandom_range(0, 4) == 0));
            end
            wait_drained();
        end

        $display("Covered %0d results, %0d evaluated windows and %0d thread steps",
                 results_seen, evals_seen, adjusts_seen);
        $display("across eight register settings, new days, and long output stalls.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> windowed_percentile_thread_governor_unit.f
+incdir+design
design/wptg_pkg.sv
design/wptg_cell.sv
design/wptg_div.sv
design/windowed_percentile_thread_governor_unit.sv
sim/tb.sv
